/* hw/rtl/srtl_pkg.sv */
// ----------------------------------------------------------------------------
// srtl_pkg: shared types of the sorted region table lookup unit
// Field widths, operation and status codes, and the structs passed between
// the top level and the row of table cells.
// ----------------------------------------------------------------------------
package srtl_pkg;

  localparam int unsigned MaxRegionsDef = 16;
  localparam int unsigned AddrW         = 64;
  localparam int unsigned FlagsW        = 8;
  localparam int unsigned OpW           = 2;
  localparam int unsigned StatusW       = 2;

  // base, limit, flags, lookup address
  localparam int unsigned InDataW = 3 * AddrW + FlagsW;

  // status, found, found base, found limit, found flags, from last hit
  localparam int unsigned OutFixedW = StatusW + 1 + 2 * AddrW + FlagsW + 1;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_OVERLAP = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic [AddrW-1:0]  base;
    logic [AddrW-1:0]  limit;
    logic [FlagsW-1:0] flags;
  } entry_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic              insert;   // committed insert (status ok)
    logic              lookup;   // committed lookup that hit
    logic              clear;
    logic [AddrW-1:0]  base;
    logic [AddrW-1:0]  limit;
    logic [FlagsW-1:0] flags;
    logic [AddrW-1:0]  addr;
  } cmd_t;

  // What one cell hands to the cell above it
  typedef struct packed {
    entry_t entry;
    logic   le;      // holds an entry whose base is not above the insert base
    logic   valid;
    logic   lh;      // this entry is the last hit
  } link_t;

  typedef struct packed {
    logic hit;       // entry contains the lookup address
    logic ovl;       // insert range collides with this entry
  } cell_stat_t;

endpackage

/* hw/rtl/sorted_region_table_lookup_unit.sv */
// ----------------------------------------------------------------------------
// sorted_region_table_lookup_unit: sorted address region table with lookup
// Insert, look up and clear half-open address regions held sorted by base
// in a row of cells; a lookup reports the containing region and whether the
// last-hit mark answered it.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                         Handshake
//  --------  ---  ----------------------------------------------  ---------
//  s_axis    in   tuser: operation; tdata: base, limit, flags,    tvalid/tready
//                 lookup address
//  m_axis    out  tdata: status, found, found base/limit/flags,   tvalid/tready
//                 from_last_hit, entries_used
//
//  Cycles: one transaction per clock unless a held result stalls the input;
//  the result is registered and appears in the cycle after acceptance. Every
//  cell compares its region against the command in the same cycle, so the rate
//  is set by the 64-bit cell compares and the OR feeding the output register.
//  Reset: entry count, last-hit marks and output valid clear at once; the
//  region payload is not cleared and is only read below the entry count.
//  Stalls: s_axis_tready is high while the output register is empty or is
//  being drained, so a held result stalls the input until it is taken.
//
module sorted_region_table_lookup_unit #(
  parameter int unsigned MAX_REGIONS = srtl_pkg::MaxRegionsDef,
  localparam int unsigned CountW     = $clog2(MAX_REGIONS + 1),
  localparam int unsigned OutDataW   = ((srtl_pkg::OutFixedW + CountW + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [63:0] region_start, [127:64] region_end, [135:128] region_flags,
  // [199:136] lookup_address
  input  logic [srtl_pkg::InDataW-1:0] s_axis_tdata,
  // [1:0] operation
  input  logic [srtl_pkg::OpW-1:0]     s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [1:0] status, [2] found, [66:3] found_start, [130:67] found_end,
  // [138:131] found_flags, [139] from_last_hit, then entries_used, zero pad
  output logic [OutDataW-1:0]          m_axis_tdata
);

  localparam int unsigned AW = srtl_pkg::AddrW;
  localparam int unsigned FW = srtl_pkg::FlagsW;
  localparam int unsigned PadW = OutDataW - srtl_pkg::OutFixedW - CountW;

  // Input unpack
  srtl_pkg::op_e      op;
  logic [AW-1:0]      in_base;
  logic [AW-1:0]      in_limit;
  logic [FW-1:0]      in_flags;
  logic [AW-1:0]      in_addr;
  logic               in_acc;

  assign op       = srtl_pkg::op_e'(s_axis_tuser);
  assign in_base  = s_axis_tdata[AW-1:0];
  assign in_limit = s_axis_tdata[2*AW-1:AW];
  assign in_flags = s_axis_tdata[2*AW+FW-1:2*AW];
  assign in_addr  = s_axis_tdata[3*AW+FW-1:2*AW+FW];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Table state
  logic [CountW-1:0]    count_q;
  logic [CountW-1:0]    count_d;
  srtl_pkg::cmd_t       cmd;
  srtl_pkg::link_t      link_w [MAX_REGIONS+1];
  srtl_pkg::cell_stat_t stat_w [MAX_REGIONS];

  // Row-wide reductions
  logic               any_ovl;
  logic               any_hit;
  logic               hit_last;
  srtl_pkg::entry_t   hit_entry;
  srtl_pkg::status_e  ins_status;

  // Bottom of the row: an insert always may land at slot zero
  assign link_w[0] = '{entry: '0, le: 1'b1, valid: 1'b0, lh: 1'b0};

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    srtl_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .valid_i (count_q > CountW'(i)),
      .prev_i  (link_w[i]),
      .next_o  (link_w[i+1]),
      .stat_o  (stat_w[i])
    );
  end

  // Regions are disjoint, so at most one cell hits; OR its entry out.
  always_comb begin
    any_ovl   = 1'b0;
    any_hit   = 1'b0;
    hit_last  = 1'b0;
    hit_entry = '0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      any_ovl   = any_ovl | stat_w[i].ovl;
      any_hit   = any_hit | stat_w[i].hit;
      hit_last  = hit_last | (stat_w[i].hit & link_w[i+1].lh);
      hit_entry = hit_entry | (stat_w[i].hit ? link_w[i+1].entry : '0);
    end
  end

  // Empty range wins over overlap, overlap over a full table
  always_comb begin
    if (in_base >= in_limit) begin
      ins_status = srtl_pkg::ST_EMPTY;
    end else if (any_ovl) begin
      ins_status = srtl_pkg::ST_OVERLAP;
    end else if (count_q == CountW'(MAX_REGIONS)) begin
      ins_status = srtl_pkg::ST_FULL;
    end else begin
      ins_status = srtl_pkg::ST_OK;
    end
  end

  always_comb begin
    cmd.insert = in_acc && (op == srtl_pkg::OP_INSERT) && (ins_status == srtl_pkg::ST_OK);
    cmd.lookup = in_acc && (op == srtl_pkg::OP_LOOKUP) && any_hit;
    cmd.clear  = in_acc && (op == srtl_pkg::OP_CLEAR);
    cmd.base   = in_base;
    cmd.limit  = in_limit;
    cmd.flags  = in_flags;
    cmd.addr   = in_addr;
  end

  always_comb begin
    count_d = count_q;
    if (cmd.clear) begin
      count_d = '0;
    end else if (cmd.insert) begin
      count_d = count_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Output register
  logic                        out_valid_q;
  logic [srtl_pkg::StatusW-1:0] out_status_q;
  logic                        out_found_q;
  srtl_pkg::entry_t            out_entry_q;
  logic                        out_last_q;
  logic [CountW-1:0]           out_count_q;
  logic                        is_hit;

  assign is_hit = (op == srtl_pkg::OP_LOOKUP) && any_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the payload until the next accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_status_q <= (op == srtl_pkg::OP_INSERT) ? ins_status : srtl_pkg::ST_OK;
      out_found_q  <= is_hit;
      out_entry_q  <= is_hit ? hit_entry : '0;
      out_last_q   <= is_hit && hit_last;
      out_count_q  <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, out_count_q, out_last_q, out_entry_q.flags,
                          out_entry_q.limit, out_entry_q.base, out_found_q, out_status_q};

endmodule

/* hw/rtl/srtl_cell.sv */
// ----------------------------------------------------------------------------
// srtl_cell: one slot of the sorted region table
// Holds one region and its last-hit mark, compares it against the command,
// and on insert either keeps, takes the new region, or takes its neighbor's.
// ----------------------------------------------------------------------------
module srtl_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srtl_pkg::cmd_t      cmd_i,
  input  logic                valid_i,
  input  srtl_pkg::link_t     prev_i,
  output srtl_pkg::link_t     next_o,
  output srtl_pkg::cell_stat_t stat_o
);

  srtl_pkg::entry_t entry_q;
  logic             lh_q;
  logic             le;
  logic             take_new;
  logic             take_prev;

  assign le = valid_i && (entry_q.base <= cmd_i.base);

  // The new region lands right above the last entry not above its base;
  // everything above that slot moves up by one.
  assign take_new  = prev_i.le && !le;
  assign take_prev = !prev_i.le && prev_i.valid;

  assign stat_o.hit = valid_i && (entry_q.base <= cmd_i.addr) && (cmd_i.addr < entry_q.limit);
  assign stat_o.ovl = valid_i &&
                      ((le && (entry_q.limit > cmd_i.base)) ||
                       (!le && (cmd_i.limit > entry_q.base)));

  assign next_o.entry = entry_q;
  assign next_o.le    = le;
  assign next_o.valid = valid_i;
  assign next_o.lh    = lh_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      if (take_new) begin
        entry_q.base  <= cmd_i.base;
        entry_q.limit <= cmd_i.limit;
        entry_q.flags <= cmd_i.flags;
      end else if (take_prev) begin
        entry_q <= prev_i.entry;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lh_q <= 1'b0;
    end else if (cmd_i.clear) begin
      lh_q <= 1'b0;
    end else if (cmd_i.lookup) begin
      lh_q <= stat_o.hit;
    end else if (cmd_i.insert) begin
      if (take_new) begin
        lh_q <= 1'b0;
      end else if (take_prev) begin
        lh_q <= prev_i.lh;
      end
    end
  end

endmodule

/* hw/rtl/srtl_checker.sv */
// ----------------------------------------------------------------------------
// srtl_checker: port-level checks for the sorted region table lookup unit
// Watches the stream ports and flags results that break the block's rules.
// ----------------------------------------------------------------------------
module srtl_checker #(
  parameter int unsigned MAX_REGIONS = srtl_pkg::MaxRegionsDef,
  localparam int unsigned CountW     = $clog2(MAX_REGIONS + 1),
  localparam int unsigned OutDataW   = ((srtl_pkg::OutFixedW + CountW + 7) / 8) * 8
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [srtl_pkg::InDataW-1:0] s_axis_tdata,
  input logic [srtl_pkg::OpW-1:0]     s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [OutDataW-1:0]          m_axis_tdata
);

  localparam int unsigned FoundB = srtl_pkg::StatusW;
  localparam int unsigned LastB  = srtl_pkg::OutFixedW - 1;
  localparam int unsigned CntLo  = srtl_pkg::OutFixedW;

  logic clear_acc;
  assign clear_acc = s_axis_tvalid && s_axis_tready &&
                     (s_axis_tuser == srtl_pkg::OP_CLEAR) && (s_axis_tdata == s_axis_tdata);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A miss or a non-lookup carries an all-zero region
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[FoundB] |-> m_axis_tdata[LastB:FoundB] == '0)
    else $error("region fields set without a hit");

  // A refused insert never reports a found region
  a_status_nofound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[srtl_pkg::StatusW-1:0] != srtl_pkg::ST_OK)
    |-> !m_axis_tdata[FoundB])
    else $error("refused insert reports a hit");

  // A clear empties the table in its own result
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_acc |=> m_axis_tvalid && (m_axis_tdata[CntLo+CountW-1:CntLo] == '0))
    else $error("clear left entries");

  // A found region is never empty
  a_found_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[FoundB]
    |-> m_axis_tdata[FoundB+2*srtl_pkg::AddrW:FoundB+srtl_pkg::AddrW+1] >
        m_axis_tdata[FoundB+srtl_pkg::AddrW:FoundB+1])
    else $error("found region has end not above start");

endmodule

bind sorted_region_table_lookup_unit srtl_checker #(
  .MAX_REGIONS (MAX_REGIONS)
) u_srtl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
